// ----- rtl/rfp_pkg.sv -----
// ----------------------------------------------------------------------------
// rfp_pkg: shared types and constants for the rangefinder frame parser
// This package holds the input and result item structs, the register indexes
// and the frame constants.
// ----------------------------------------------------------------------------
package rfp_pkg;

  // Frame constants
  localparam logic [7:0]  HDR_BYTE = 8'h5C;
  localparam logic [16:0] AGE_MAX  = 17'h1FFFF;

  // Configuration register indexes
  localparam logic CFG_TIMEOUT_TICKS = 1'b0;
  localparam logic CFG_MAX_DISTANCE  = 1'b1;

  // Configuration reset values
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd100;
  localparam logic [15:0] MAX_DISTANCE_RST  = 16'd20000;

  // Input item opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [15:0] distance;
    logic        new_measurement;
    logic        checksum_error;
    logic        out_of_range;
    logic        stale;
  } out_t;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [15:0] max_distance;
  } cfg_t;

endpackage

// ----- rtl/rfp_core.sv -----
// ----------------------------------------------------------------------------
// rfp_core: frame window, checksum check and age counter
// Holds the pending byte window and the measurement state. On each advance
// one item is resolved combinationally and its result is produced.
// ----------------------------------------------------------------------------
module rfp_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         advance,
  input  rfp_pkg::in_t item,
  input  rfp_pkg::cfg_t cfg,
  output rfp_pkg::out_t result
);

  logic [7:0]  win0, win1, win2;
  logic [1:0]  count;
  logic [15:0] held;
  logic [16:0] age;

  logic [7:0]  win0_next, win1_next, win2_next;
  logic [1:0]  count_next;
  logic [15:0] held_next;
  logic [16:0] age_next;
  logic        newm, cerr, oor;
  logic [7:0]  csum;
  logic [15:0] frame_dist;

  // Resolve one item against the current window
  always_comb begin
    win0_next  = win0;
    win1_next  = win1;
    win2_next  = win2;
    count_next = count;
    held_next  = held;
    age_next   = age;
    newm       = 1'b0;
    cerr       = 1'b0;
    oor        = 1'b0;
    csum       = ~(win1 + win2);
    frame_dist = {win2, win1};

    if (item.op == rfp_pkg::OP_TICK) begin
      if (age != rfp_pkg::AGE_MAX) begin
        age_next = age + 17'd1;
      end
    end else begin
      case (count)
        2'd0: begin
          if (item.data_byte == rfp_pkg::HDR_BYTE) begin
            win0_next  = item.data_byte;
            count_next = 2'd1;
          end
        end
        2'd1: begin
          win1_next  = item.data_byte;
          count_next = 2'd2;
        end
        2'd2: begin
          win2_next  = item.data_byte;
          count_next = 2'd3;
        end
        default: begin
          if (csum == item.data_byte) begin
            // Good frame: consume it whole
            count_next = 2'd0;
            if (frame_dist != 16'd0 && frame_dist <= cfg.max_distance) begin
              held_next = frame_dist;
              age_next  = '0;
              newm      = 1'b1;
            end else begin
              oor = 1'b1;
            end
          end else begin
            // Bad frame: drop the header and resync on the next header
            cerr = 1'b1;
            if (win1 == rfp_pkg::HDR_BYTE) begin
              win0_next  = win1;
              win1_next  = win2;
              win2_next  = item.data_byte;
              count_next = 2'd3;
            end else if (win2 == rfp_pkg::HDR_BYTE) begin
              win0_next  = win2;
              win1_next  = item.data_byte;
              count_next = 2'd2;
            end else if (item.data_byte == rfp_pkg::HDR_BYTE) begin
              win0_next  = item.data_byte;
              count_next = 2'd1;
            end else begin
              count_next = 2'd0;
            end
          end
        end
      endcase
    end

    result.distance        = held_next;
    result.new_measurement = newm;
    result.checksum_error  = cerr;
    result.out_of_range    = oor;
    result.stale           = (age_next > {1'b0, cfg.timeout_ticks});
  end

  // Control and measurement state
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      held  <= '0;
      age   <= '0;
    end else if (advance) begin
      count <= count_next;
      held  <= held_next;
      age   <= age_next;
    end
  end

  // Window bytes are qualified by count
  always_ff @(posedge clk) begin
    if (advance) begin
      win0 <= win0_next;
      win1 <= win1_next;
      win2 <= win2_next;
    end
  end

endmodule

// ----- rtl/rfp_out_buf.sv -----
// ----------------------------------------------------------------------------
// rfp_out_buf: two-entry result buffer
// Decouples the result channel from the core so that a stalled receiver does
// not stall the core until both entries are full.
// ----------------------------------------------------------------------------
module rfp_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rfp_pkg::out_t push_item,
  output logic          full,
  output logic          out_valid,
  input  logic          out_stall,
  output rfp_pkg::out_t out_item
);

  rfp_pkg::out_t mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          pop;

  assign pop       = out_valid && !out_stall;
  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_item  = mem[rd_ptr];

  // Store a result on push
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/rangefinder_frame_parser.sv -----
// ----------------------------------------------------------------------------
// rangefinder_frame_parser: serial rangefinder frame parser, one channel
// Takes received bytes and millisecond ticks and reports the held distance,
// frame status flags and a stale flag for every item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_item) carries one byte or one
//   tick per transfer. Every accepted item gives exactly one result on the
//   output channel (out_valid / out_stall / out_item), in order.
//   An item is captured in the input register, resolved there against the
//   frame window once the buffer has room, and the result lands in a
//   two-entry buffer, whose occupancy drives out_valid. Throughput is one
//   item per cycle while the buffer is not full; the frame check and age
//   update are a single pass of logic between the input register and the
//   result buffer. When the receiver stalls, results collect in the buffer;
//   once it holds two, the input register holds its item and in_stall
//   rises. Configuration (cfg_we / cfg_index / cfg_data) writes
//   timeout_ticks (index 0) and max_distance (index 1); the user must write
//   them only while the block is idle; the block does not enforce this.
//   Synchronous reset empties the window and buffer, clears distance and
//   age, and restores timeout_ticks to 100 and max_distance to 20000.
// ----------------------------------------------------------------------------
module rangefinder_frame_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  rfp_pkg::in_t  in_item,
  output logic          out_valid,
  input  logic          out_stall,
  output rfp_pkg::out_t out_item,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_data
);

  rfp_pkg::cfg_t cfg;
  rfp_pkg::in_t  s1_item;
  logic          s1_valid;
  logic          buf_full;
  logic          advance;
  logic          in_xfer;
  rfp_pkg::out_t result;

  assign advance  = s1_valid && !buf_full;
  assign in_stall = s1_valid && buf_full;
  assign in_xfer  = in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks <= rfp_pkg::TIMEOUT_TICKS_RST;
      cfg.max_distance  <= rfp_pkg::MAX_DISTANCE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rfp_pkg::CFG_TIMEOUT_TICKS: cfg.timeout_ticks <= cfg_data;
        rfp_pkg::CFG_MAX_DISTANCE:  cfg.max_distance  <= cfg_data;
        default:                    cfg <= cfg;
      endcase
    end
  end

  // Input register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Capture the item on transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item <= in_item;
    end
  end

  rfp_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (s1_item),
    .cfg     (cfg),
    .result  (result)
  );

  rfp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (advance),
    .push_item (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
